[rtl/core/bss_pkg.sv]
// Shared package for the byte stack with search.
// Holds request codes, cell shift modes, field widths and the cell control struct.
// No dependencies.
package bss_pkg;

    // Built depth default and fixed field widths
    localparam int BSS_DEPTH     = 64;
    localparam int BYTE_W        = 8;
    localparam int OPCODE_W      = 3;
    localparam int CAP_W         = 7;
    localparam int POS_W         = 6;
    localparam int SIZE_W        = 7;
    localparam int IN_TDATA_W    = 8;
    localparam int IN_TUSER_W    = 8;
    localparam int OUT_TDATA_W   = 24;

    // Request codes
    typedef logic [OPCODE_W-1:0] opcode_t;
    localparam opcode_t OP_PUSH   = 3'd0;
    localparam opcode_t OP_POP    = 3'd1;
    localparam opcode_t OP_PEEK   = 3'd2;
    localparam opcode_t OP_CLEAR  = 3'd3;
    localparam opcode_t OP_SEARCH = 3'd4;

    // Per-cycle movement of the cell row
    typedef logic [1:0] cell_mode_t;
    localparam cell_mode_t MODE_HOLD   = 2'd0;
    localparam cell_mode_t MODE_PUSH   = 2'd1;  // shift away from the top
    localparam cell_mode_t MODE_POP    = 2'd2;  // shift toward the top
    localparam cell_mode_t MODE_ROTATE = 2'd3;  // shift toward the top, head wraps

    typedef struct packed {
        cell_mode_t          mode;
        logic [BYTE_W-1:0]   push_byte;
    } cell_ctrl_t;

endpackage

[rtl/core/bss_cell.sv]
// One storage cell of the stack row.
// Holds one byte and takes a neighbor's byte as the row shifts; uses bss_pkg.
module bss_cell
    import bss_pkg::*;
#(
    parameter int AW  = 6,
    parameter int IDX = 0
)
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [AW-1:0]     wrap_idx,
    input  logic [BYTE_W-1:0] from_above,
    input  logic [BYTE_W-1:0] from_below,
    input  logic [BYTE_W-1:0] head_in,
    output logic [BYTE_W-1:0] data
);

    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] data_next;

    always_comb
    begin
        unique case (ctrl.mode)
            MODE_PUSH:   data_next = from_above;
            MODE_POP:    data_next = from_below;
            MODE_ROTATE: data_next = (wrap_idx == AW'(IDX)) ? head_in : from_below;
            default:     data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[rtl/core/bss_chain.sv]
// Row of DEPTH stack cells, cell 0 at the top of the stack.
// Wires each cell to its neighbors; uses bss_pkg and bss_cell.
module bss_chain
    import bss_pkg::*;
#(
    parameter int DEPTH = BSS_DEPTH,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [AW-1:0]     wrap_idx,
    output logic [BYTE_W-1:0] head
);

    logic [BYTE_W-1:0] cell_q [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [BYTE_W-1:0] above;
        logic [BYTE_W-1:0] below;

        if (i == 0)
        begin : g_top
            assign above = ctrl.push_byte;
        end
        else
        begin : g_mid_a
            assign above = cell_q[i-1];
        end

        if (i == DEPTH-1)
        begin : g_bottom
            assign below = '0;
        end
        else
        begin : g_mid_b
            assign below = cell_q[i+1];
        end

        bss_cell #(
            .AW  (AW),
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .wrap_idx   (wrap_idx),
            .from_above (above),
            .from_below (below),
            .head_in    (cell_q[0]),
            .data       (cell_q[i])
        );
    end

    assign head = cell_q[0];

endmodule

[rtl/core/byte_stack_with_search_unit.sv]
// Byte stack with search: top level with request control and result register.
// Push, pop, peek, clear and unused codes: result registered when the request is accepted.
// Search: rotates the held entries once through the top cell; result registered
//   once the full turn is done and the result slot is free, then the next word is taken.
// One request in flight; a new word is taken while the last result is drained.
// Reset (rst_n low, async): stack empty, capacity 64, no result pending.
module byte_stack_with_search_unit
    import bss_pkg::*;
#(
    parameter int DEPTH = BSS_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Capacity register write
    input  logic                   capacity_wr_en,
    input  logic [CAP_W-1:0]       capacity_wr_data,
    // Request stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] data_in
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,  // [2:0] opcode, [7:3] zero
    // Result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [0] status, [8:1] data_out,
                                                  // [14:9] found_position,
                                                  // [21:15] size_now,
                                                  // [22] empty_flag, [23] full_flag
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
    localparam int PW   = (AW > POS_W) ? AW : POS_W;

    localparam logic ST_RUN    = 1'b0;
    localparam logic ST_SEARCH = 1'b1;

    // Control state
    logic                    state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CAP_W-1:0]        cap_reg;
    logic [CW-1:0]           step_reg, step_next;
    logic                    found_reg, found_next;
    logic [AW-1:0]           pos_reg, pos_next;
    logic [BYTE_W-1:0]       key_reg, key_next;
    logic                    out_valid_reg;
    logic [OUT_TDATA_W-1:0]  out_data_reg;

    // Result under construction
    logic                    out_load;
    logic                    res_status;
    logic [BYTE_W-1:0]       res_dout;
    logic [AW-1:0]           res_pos;

    logic                    out_free;
    logic                    in_fire;
    opcode_t                 opcode;
    logic [BYTE_W-1:0]       data_in;
    logic [BYTE_W-1:0]       head;
    cell_ctrl_t              cell_ctrl;
    logic [CW-1:0]           last_slot;
    logic [AW-1:0]           wrap_idx;
    logic [CMPW-1:0]         cap_eff;
    logic [CMPW-1:0]         count_ext;
    logic [CMPW-1:0]         count_next_ext;
    logic [CW-1:0]           match_pos;
    logic [PW-1:0]           pos_ext;

    assign opcode  = s_axis_tuser[OPCODE_W-1:0];
    assign data_in = s_axis_tdata[BYTE_W-1:0];

    // Accept a request only when the result slot is free or drains this cycle
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_RUN) && out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Effective capacity is the smaller of the register and the built depth
    assign count_ext      = CMPW'(count_reg);
    assign count_next_ext = CMPW'(count_next);
    always_comb
    begin
        if (CMPW'(cap_reg) < CMPW'(DEPTH))
            cap_eff = CMPW'(cap_reg);
        else
            cap_eff = CMPW'(DEPTH);
    end

    // During a rotation the bottom entry (count-1) refills from the head
    assign last_slot = count_reg - CW'(1);
    assign wrap_idx  = last_slot[AW-1:0];
    assign match_pos = last_slot - step_reg;

    always_comb
    begin
        state_next          = state_reg;
        count_next          = count_reg;
        step_next           = step_reg;
        found_next          = found_reg;
        pos_next            = pos_reg;
        key_next            = key_reg;
        cell_ctrl.mode      = MODE_HOLD;
        cell_ctrl.push_byte = data_in;
        out_load            = 1'b0;
        res_status          = 1'b1;
        res_dout            = '0;
        res_pos             = '0;

        if (state_reg == ST_RUN)
        begin
            if (in_fire)
            begin
                out_load = 1'b1;
                unique case (opcode)
                    OP_PUSH:
                    begin
                        if (count_ext < cap_eff)
                        begin
                            cell_ctrl.mode = MODE_PUSH;
                            count_next     = count_reg + CW'(1);
                            res_status     = 1'b0;
                        end
                    end
                    OP_POP:
                    begin
                        if (count_reg != '0)
                        begin
                            cell_ctrl.mode = MODE_POP;
                            count_next     = count_reg - CW'(1);
                            res_dout       = head;
                            res_status     = 1'b0;
                        end
                    end
                    OP_PEEK:
                    begin
                        if (count_reg != '0)
                        begin
                            res_dout   = head;
                            res_status = 1'b0;
                        end
                    end
                    OP_CLEAR:
                    begin
                        count_next = '0;
                        res_status = 1'b0;
                    end
                    OP_SEARCH:
                    begin
                        // Result comes after the rotation
                        out_load   = 1'b0;
                        state_next = ST_SEARCH;
                        step_next  = '0;
                        found_next = 1'b0;
                        pos_next   = '0;
                        key_next   = data_in;
                    end
                    default:
                    begin
                        res_status = 1'b1;
                    end
                endcase
            end
        end
        else
        begin
            if (step_reg != count_reg)
            begin
                // Advance the rotation; the first hit is the topmost match
                cell_ctrl.mode = MODE_ROTATE;
                step_next      = step_reg + CW'(1);
                if (!found_reg && (head == key_reg))
                begin
                    found_next = 1'b1;
                    pos_next   = match_pos[AW-1:0];
                end
            end
            else if (out_free)
            begin
                // Full turn done: the stack is back in place
                out_load   = 1'b1;
                res_status = !found_reg;
                res_pos    = pos_reg;
                state_next = ST_RUN;
            end
        end
    end

    assign pos_ext = PW'(res_pos);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            count_reg     <= '0;
            cap_reg       <= CAP_W'(64);
            step_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            found_reg <= found_next;
            if (capacity_wr_en)
                cap_reg <= capacity_wr_data;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        key_reg <= key_next;
        if (out_load)
        begin
            out_data_reg <= {
                (count_next_ext >= cap_eff),
                (count_next == '0),
                count_next_ext[SIZE_W-1:0],
                pos_ext[POS_W-1:0],
                res_dout,
                res_status
            };
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    bss_chain #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_chain (
        .clk      (clk),
        .ctrl     (cell_ctrl),
        .wrap_idx (wrap_idx),
        .head     (head)
    );

endmodule
